>>> hw/rtl/jljt_pkg.sv
// shared types, constants and saturation helpers of the jerk-limited trajectory block
// no dependencies
`default_nettype none

package jljt_pkg;

    localparam int NUM_VALUE_FIELDS = 7;
    localparam int NUM_LIMIT_REGS   = 7;
    localparam logic [16:0] DT_MAX_US = 17'd100000;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_GOAL = 2'd1,
        ACT_STEP = 2'd2
    } t_action;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOT_INIT = 2'd1;
    localparam logic [1:0] STAT_BAD_DT   = 2'd2;

    typedef enum logic [1:0] {
        DIV_JERK = 2'd0,
        DIV_VEL  = 2'd1,
        DIV_POS  = 2'd2
    } t_div_sel;

    // all three divisors are this odd factor times a power of two
    localparam logic [13:0] DIVISOR = 14'd15625;
    // ceil(2^62 / DIVISOR), exact floor for numerators below 2^48
    localparam logic [48:0] RECIP   = 49'd295147905179353;

    typedef logic signed [39:0] t_wide;

    typedef struct packed {
        logic load;
        logic goal_wr;
        logic start;
    } t_lane_cmd;

    function automatic t_wide clamp_sym(input t_wide x, input t_wide lim);
        t_wide r;
        if (x > lim) r = lim;
        else if (x < -lim) r = -lim;
        else r = x;
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input t_wide x);
        logic signed [31:0] r;
        if (x > 40'sd2147483647) r = 32'sh7fffffff;
        else if (x < -40'sd2147483648) r = 32'sh80000000;
        else r = x[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/jerk_limited_joint_trajectory.sv
// top level of the jerk-limited joint setpoint generator: lanes, limit registers, result merge
// uses jljt_pkg and jljt_lane
//
// usage:
//  - input stream: tuser carries the action (load positions, set goal, step), tdata the
//    seven joint values and the step time in microseconds
//  - load and set goal produce no item
//  - a step runs all joint lanes side by side; a lane's sequence is set by its
//    reciprocal-multiply divider, used three times in a row (jerk step, velocity change,
//    position change); a lane already settled snaps to its goal without the divider
//  - the first result item is offered once no lane is busy any more
//  - the merge then sends one item per joint, lowest joint first, tlast on the final one,
//    one item per cycle while the receiver is ready
//  - a step while not initialised or with a bad time step gives one error item the next
//    cycle
//  - tready stays low from an accepted step until its last item is taken; a stalled
//    receiver simply holds the current item
//  - reset (synchronous, active low) clears the limits, all joint state and the
//    initialised flag; write limit registers via the plain write port while idle (unenforced)
`default_nettype none

module jerk_limited_joint_trajectory import jljt_pkg::*; #(
    parameter int JOINT_COUNT = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // limit registers
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [63:0]   i_cfg_data,
    // input stream
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // value_joint0..6 [223:0], step_time_us [240:224], zero [247:241]
    input  wire logic [247:0]  i_s_axis_tdata,
    // action [1:0]
    input  wire logic [1:0]    i_s_axis_tuser,
    // result stream
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // joint_number [2:0], position_out [34:3], velocity_out [66:35],
    // acceleration_out [98:67], zero [103:99]
    output logic [103:0]       o_m_axis_tdata,
    // status [1:0]
    output logic [1:0]         o_m_axis_tuser,
    output logic               o_m_axis_tlast
);

    localparam int IW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } t_top_state;

    t_top_state      r_state;
    logic [63:0]     r_limits [NUM_LIMIT_REGS];
    logic            r_init;
    logic            r_err;
    logic [1:0]      r_status;
    logic [IW-1:0]   r_idx;

    logic            in_acc, out_acc, dt_bad, last_item;
    logic [16:0]     dt;
    t_lane_cmd       cmd;
    logic [JOINT_COUNT-1:0] busy;
    logic signed [31:0] w_pos [JOINT_COUNT];
    logic signed [31:0] w_vel [JOINT_COUNT];
    logic signed [31:0] w_acc [JOINT_COUNT];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign dt      = i_s_axis_tdata[240:224];
    assign dt_bad  = (dt == 17'd0) || (dt > DT_MAX_US);

    // commands to the lanes, taken on the accept edge
    always_comb begin
        cmd = '0;
        if (in_acc) begin
            case (i_s_axis_tuser)
                ACT_LOAD: cmd.load = 1'b1;
                ACT_GOAL: begin
                    cmd.load    = !r_init;
                    cmd.goal_wr = r_init;
                end
                ACT_STEP: cmd.start = r_init && !dt_bad;
                default:  cmd = '0;
            endcase
        end
    end

    for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_lane
        logic signed [31:0] lane_value;
        logic [63:0]        lane_limits;
        if (j < NUM_VALUE_FIELDS) begin : g_fed
            assign lane_value  = i_s_axis_tdata[32*j +: 32];
            assign lane_limits = r_limits[j];
        end else begin : g_zero
            // joints past the input fields see zero values and zero limits
            assign lane_value  = '0;
            assign lane_limits = '0;
        end
        jljt_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (cmd),
            .i_value  (lane_value),
            .i_dt     (dt),
            .i_limits (lane_limits),
            .o_busy   (busy[j]),
            .o_pos    (w_pos[j]),
            .o_vel    (w_vel[j]),
            .o_acc    (w_acc[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LIMIT_REGS; k++) r_limits[k] <= '0;
        end else if (i_cfg_we && (i_cfg_idx < 3'(NUM_LIMIT_REGS))) begin
            r_limits[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign last_item = r_err || (r_idx == IW'(JOINT_COUNT - 1));

    // control: accept, wait for all lanes (not on error), then merge results in joint order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_init   <= 1'b0;
            r_err    <= 1'b0;
            r_status <= STAT_OK;
            r_idx    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: if (in_acc) begin
                    if (cmd.load) r_init <= 1'b1;
                    if (i_s_axis_tuser == ACT_STEP) begin
                        r_idx <= '0;
                        if (!r_init) begin
                            r_err    <= 1'b1;
                            r_status <= STAT_NOT_INIT;
                            r_state  <= ST_EMIT;
                        end else if (dt_bad) begin
                            r_err    <= 1'b1;
                            r_status <= STAT_BAD_DT;
                            r_state  <= ST_EMIT;
                        end else begin
                            r_err    <= 1'b0;
                            r_status <= STAT_OK;
                            r_state  <= ST_RUN;
                        end
                    end
                end
                ST_RUN: if (busy == '0) r_state <= ST_EMIT;
                ST_EMIT: if (out_acc) begin
                    if (last_item) r_state <= ST_IDLE;
                    else r_idx <= r_idx + IW'(1);
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = (r_state == ST_EMIT);
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tlast  = last_item;
    assign o_m_axis_tdata  = r_err ? '0
                           : {5'd0, w_acc[r_idx], w_vel[r_idx], w_pos[r_idx], 3'(r_idx)};

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_m_axis_tvalid && o_s_axis_tready))
        else $error("result offered while input is open");

    a_lanes_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy != '0) |-> (r_state == ST_RUN))
        else $error("lane busy outside the run phase");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != STAT_OK) |-> o_m_axis_tlast)
        else $error("error item without tlast");

    a_step_needs_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |-> r_init)
        else $error("lanes started while not initialised");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/jljt_cdiv.sv
// floor divider of a signed value by one of three fixed divisors, reciprocal multiply
// over four partial products; uses jljt_pkg
`default_nettype none

module jljt_cdiv import jljt_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire t_div_sel            i_sel,
    input  wire logic signed [50:0]  i_num,
    output logic                     o_done,
    output logic signed [50:0]       o_quot
);

    logic [47:0] r_m;
    logic        r_neg;
    logic [96:0] r_acc;
    logic [1:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic signed [50:0] scaled;
    logic [47:0] mag;
    logic [23:0] m_part;
    logic [24:0] c_part;
    logic [48:0] pprod;
    logic [96:0] pp_shift;
    logic [34:0] quot_mag;

    // power-of-two part of the divisor comes off first
    always_comb begin
        case (i_sel)
            DIV_JERK: scaled = i_num;
            DIV_VEL:  scaled = i_num >>> 2;
            DIV_POS:  scaled = i_num >>> 6;
            default:  scaled = i_num >>> 6;
        endcase
    end

    // floor for negative numerators: magnitude rounded up before the unsigned divide
    assign mag = scaled[50] ? 48'(-scaled) + 48'(DIVISOR - 14'd1) : 48'(scaled);

    assign m_part = r_cnt[1] ? r_m[47:24] : r_m[23:0];
    assign c_part = r_cnt[0] ? {1'b0, RECIP[48:25]} : RECIP[24:0];
    assign pprod  = m_part * c_part;

    always_comb begin
        case (r_cnt)
            2'd0:    pp_shift = 97'(pprod);
            2'd1:    pp_shift = 97'(pprod) << 25;
            2'd2:    pp_shift = 97'(pprod) << 24;
            default: pp_shift = 97'(pprod) << 49;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_m    <= '0;
            r_neg  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_m    <= mag;
                r_neg  <= scaled[50];
            end else if (r_busy) begin
                r_acc <= r_acc + pp_shift;
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign quot_mag = r_acc[96:62];
    assign o_done   = r_done;
    assign o_quot   = r_neg ? -$signed({16'd0, quot_mag}) : $signed({16'd0, quot_mag});

endmodule

`default_nettype wire

>>> hw/rtl/jljt_lane.sv
// one joint lane: goal, position, velocity and acceleration state and the step sequencer
// uses jljt_pkg and jljt_cdiv
`default_nettype none

module jljt_lane import jljt_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_lane_cmd          i_cmd,
    input  wire logic signed [31:0] i_value,
    input  wire logic [16:0]        i_dt,
    input  wire logic [63:0]        i_limits,
    output logic                    o_busy,
    output logic signed [31:0]      o_pos,
    output logic signed [31:0]      o_vel,
    output logic signed [31:0]      o_acc
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_JERK = 9'b000000010,
        S_ACC  = 9'b000000100,
        S_VMUL = 9'b000001000,
        S_VEL  = 9'b000010000,
        S_VUPD = 9'b000100000,
        S_PMUL = 9'b001000000,
        S_POS  = 9'b010000000,
        S_PUPD = 9'b100000000
    } t_lane_state;

    t_lane_state        r_state;
    logic signed [31:0] r_g, r_p, r_v, r_a;
    logic [16:0]        r_dt;
    logic               r_epos, r_eneg;
    t_wide              r_ag;
    t_wide              r_q;

    logic signed [32:0] err;
    logic signed [41:0] e42, v42, lin;
    t_wide              ag, amax, vmax, a_w, v_w, p_w, da, p_new;
    logic               settled;
    logic [38:0]        jprod;
    logic signed [49:0] mprod;
    logic               div_start, div_done;
    t_div_sel           div_sel;
    logic signed [50:0] div_num, div_quot;

    assign vmax = t_wide'({i_limits[19:0], 12'd0});
    assign amax = t_wide'({i_limits[41:20], 10'd0});
    assign a_w  = t_wide'(r_a);
    assign v_w  = t_wide'(r_v);
    assign p_w  = t_wide'(r_p);

    assign err = 33'(r_g) - 33'(r_p);
    assign settled = (err > -33'sd2) && (err < 33'sd2) && (r_v > -32'sd17) &&
                     (r_v < 32'sd17) && (r_a > -32'sd11) && (r_a < 32'sd11);

    // acceleration goal: floor((81 e - 36 v) / 64), clamped to +-amax
    assign e42 = 42'(err);
    assign v42 = 42'(r_v);
    assign lin = (e42 <<< 6) + (e42 <<< 4) + e42 - (v42 <<< 5) - (v42 <<< 2);
    assign ag  = clamp_sym(t_wide'(lin >>> 6), amax);

    assign jprod = i_limits[63:42] * i_dt;
    assign mprod = (r_state == S_VMUL) ? r_a * $signed({1'b0, r_dt})
                                       : r_v * $signed({1'b0, r_dt});

    assign da    = clamp_sym(r_ag - a_w, r_q);
    assign p_new = t_wide'(sat32(p_w + r_q));

    always_comb begin
        div_start = 1'b0;
        div_sel   = DIV_JERK;
        div_num   = $signed({4'd0, jprod, 8'd0});
        case (r_state)
            S_IDLE: div_start = i_cmd.start && !settled;
            S_VMUL: begin
                div_start = 1'b1;
                div_sel   = DIV_VEL;
                div_num   = 51'(mprod) + 51'sd31250;
            end
            S_PMUL: begin
                div_start = 1'b1;
                div_sel   = DIV_POS;
                div_num   = 51'(mprod) + 51'sd500000;
            end
            default: div_start = 1'b0;
        endcase
    end

    jljt_cdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sel   (div_sel),
        .i_num   (div_num),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_g <= '0;
            r_p <= '0;
            r_v <= '0;
            r_a <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.load) begin
                        r_g <= i_value;
                        r_p <= i_value;
                        r_v <= '0;
                        r_a <= '0;
                    end else if (i_cmd.goal_wr) begin
                        r_g <= i_value;
                    end else if (i_cmd.start) begin
                        if (settled) begin
                            r_p <= r_g;
                            r_v <= '0;
                            r_a <= '0;
                        end else begin
                            r_ag    <= ag;
                            r_epos  <= err > 33'sd0;
                            r_eneg  <= err < 33'sd0;
                            r_dt    <= i_dt;
                            r_state <= S_JERK;
                        end
                    end
                end
                S_JERK: if (div_done) begin
                    r_q     <= div_quot[39:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_a     <= sat32(clamp_sym(a_w + da, amax));
                    r_state <= S_VMUL;
                end
                S_VMUL: r_state <= S_VEL;
                S_VEL: if (div_done) begin
                    r_q     <= div_quot[39:0];
                    r_state <= S_VUPD;
                end
                S_VUPD: begin
                    r_v     <= sat32(clamp_sym(v_w + r_q, vmax));
                    r_state <= S_PMUL;
                end
                S_PMUL: r_state <= S_POS;
                S_POS: if (div_done) begin
                    r_q     <= div_quot[39:0];
                    r_state <= S_PUPD;
                end
                S_PUPD: begin
                    // overshoot snaps the joint onto its goal
                    if ((r_epos && p_new >= t_wide'(r_g)) ||
                        (r_eneg && p_new <= t_wide'(r_g))) begin
                        r_p <= r_g;
                        r_v <= '0;
                        r_a <= '0;
                    end else begin
                        r_p <= p_new[31:0];
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_pos  = r_p;
    assign o_vel  = r_v;
    assign o_acc  = r_a;

endmodule

`default_nettype wire
